FILE: design/psp_pkg.sv
package psp_pkg;

    localparam int SERVERS     = 4;
    localparam int PRIORITIES  = 2;
    localparam int MAX_RESULTS = 4;

    localparam int FUNC_W    = 2;
    localparam int PRIO_W    = 3;
    localparam int SID_W     = 4;
    localparam int ACT_W     = 3;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 6;

    localparam int SRV_IDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int PIDX_W    = $clog2(PRIORITIES);
    localparam int CUR_W     = $clog2(SERVERS + 1);
    localparam int NRES_W    = $clog2(MAX_RESULTS + 1);
    localparam int TOT_W     = CNT_W + $clog2(PRIORITIES);

    // event kinds
    localparam logic [FUNC_W-1:0] FN_ARRIVE   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_COMPLETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CHECK    = 2'd2;

    // result actions
    localparam logic [ACT_W-1:0] ACT_START   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PREEMPT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_QUEUED  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REFUSED = 3'd3;
    localparam logic [ACT_W-1:0] ACT_IDLE    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b1;

    localparam logic [CFG_W-1:0] QUEUE_LIMIT_RST = 6'd6;
    localparam logic [CFG_W-1:0] THRESHOLD_RST   = 6'd2;

    typedef logic [PRIO_W-1:0] prio_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [PRIORITIES-1:0][CNT_W-1:0] cnt_vec_t;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic last;
    } sts_t;

endpackage

FILE: design/psp_evt_if.sv
interface psp_evt_if;
    logic                        valid;
    logic                        ready;
    logic [psp_pkg::FUNC_W-1:0]  func;
    logic [psp_pkg::PRIO_W-1:0]  job_priority;
    logic [psp_pkg::SID_W-1:0]   server_id;

    modport source (output valid, output func, output job_priority, output server_id,
                    input ready);
    modport sink (input valid, input func, input job_priority, input server_id,
                  output ready);
endinterface

FILE: design/psp_res_if.sv
interface psp_res_if;
    logic                       valid;
    logic                       ready;
    logic [psp_pkg::ACT_W-1:0]  action;
    logic [psp_pkg::SID_W-1:0]  server_sel;
    logic [psp_pkg::PRIO_W-1:0] started_priority;
    logic [psp_pkg::PRIO_W-1:0] preempted_priority;
    logic [psp_pkg::PRIO_W-1:0] lost_priority;
    logic                       last;

    modport source (output valid, output action, output server_sel,
                    output started_priority, output preempted_priority,
                    output lost_priority, output last, input ready);
    modport sink (input valid, input action, input server_sel,
                  input started_priority, input preempted_priority,
                  input lost_priority, input last, output ready);
endinterface

FILE: design/psp_ctrl.sv
module psp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           evt_valid,
    output logic           evt_ready,
    output logic           res_valid,
    input  logic           res_ready,
    output psp_pkg::cmd_t  cmd,
    input  psp_pkg::sts_t  sts
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic res_valid_reg;
    logic res_valid_next;

    assign evt_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        cmd.load = evt_valid && (state_reg == S_IDLE);
        // one step per free output slot
        cmd.step = (state_reg == S_RUN) && (!res_valid_reg || res_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (cmd.step && sts.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.step)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

FILE: design/psp_dp.sv
module psp_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  psp_pkg::cmd_t                    cmd,
    output psp_pkg::sts_t                    sts,
    input  logic                             cfg_we,
    input  logic [psp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psp_pkg::CFG_W-1:0]        cfg_data,
    input  logic [psp_pkg::FUNC_W-1:0]       func,
    input  logic [psp_pkg::PRIO_W-1:0]       job_priority,
    input  logic [psp_pkg::SID_W-1:0]        server_id,
    output logic [psp_pkg::ACT_W-1:0]        action,
    output logic [psp_pkg::SID_W-1:0]        server_sel,
    output logic [psp_pkg::PRIO_W-1:0]       started_priority,
    output logic [psp_pkg::PRIO_W-1:0]       preempted_priority,
    output logic [psp_pkg::PRIO_W-1:0]       lost_priority,
    output logic                             last
);

    typedef struct packed {
        psp_pkg::cnt_vec_t wc;
        psp_pkg::prio_t    lost;
    } enq_t;

    // Queue a job of priority p; displace the lowest waiting job below p when full.
    function automatic enq_t enqueue(psp_pkg::cnt_vec_t wc, psp_pkg::prio_t p,
                                     psp_pkg::cnt_t limit);
        enq_t                          r;
        logic [psp_pkg::TOT_W-1:0]     total;
        logic                          done;
        logic [psp_pkg::PIDX_W-1:0]    pi;
        r     = '{wc: wc, lost: p};
        total = '0;
        done  = 1'b0;
        pi    = psp_pkg::PIDX_W'(p - 1'b1);
        for (int i = 0; i < psp_pkg::PRIORITIES; i++)
        begin
            total = total + psp_pkg::TOT_W'(wc[i]);
        end
        if (total < psp_pkg::TOT_W'(limit))
        begin
            r.wc[pi] = wc[pi] + 1'b1;
            r.lost   = '0;
        end
        else
        begin
            for (int lo = psp_pkg::PRIORITIES; lo >= 1; lo--)
            begin
                if (!done && (lo > int'(p)) && (wc[lo-1] != '0))
                begin
                    r.wc[lo-1] = wc[lo-1] - 1'b1;
                    r.wc[pi]   = r.wc[pi] + 1'b1;
                    r.lost     = psp_pkg::PRIO_W'(lo);
                    done       = 1'b1;
                end
            end
        end
        return r;
    endfunction

    psp_pkg::prio_t                  srv_reg [psp_pkg::SERVERS];
    psp_pkg::prio_t                  srv_next [psp_pkg::SERVERS];
    psp_pkg::cnt_vec_t               wc_reg;
    psp_pkg::cnt_vec_t               wc_next;
    psp_pkg::cnt_t                   qlim_reg;
    psp_pkg::cnt_t                   thr_reg;

    logic [psp_pkg::FUNC_W-1:0]      func_reg;
    psp_pkg::prio_t                  k_reg;
    logic [psp_pkg::SID_W-1:0]       sid_reg;
    logic                            en_reg;
    logic [psp_pkg::CUR_W-1:0]       cur_reg;
    logic [psp_pkg::CUR_W-1:0]       cur_next;
    logic [psp_pkg::NRES_W-1:0]      nres_reg;
    logic [psp_pkg::NRES_W-1:0]      nres_next;
    psp_pkg::prio_t                  k_clamped;

    logic [psp_pkg::ACT_W-1:0]       action_reg;
    logic [psp_pkg::ACT_W-1:0]       action_next;
    logic [psp_pkg::SID_W-1:0]       sidx_reg;
    logic [psp_pkg::SID_W-1:0]       sidx_next;
    psp_pkg::prio_t                  started_reg;
    psp_pkg::prio_t                  started_next;
    psp_pkg::prio_t                  pre_reg;
    psp_pkg::prio_t                  pre_next;
    psp_pkg::prio_t                  lost_reg;
    psp_pkg::prio_t                  lost_next;
    logic                            last_reg;
    logic                            last_next;

    logic                            free_found;
    logic [psp_pkg::SRV_IDX_W-1:0]   free_idx;
    logic                            pre_found;
    logic [psp_pkg::SRV_IDX_W-1:0]   pre_idx;
    psp_pkg::prio_t                  pre_low;
    logic                            chk_found;
    logic [psp_pkg::SRV_IDX_W-1:0]   chk_idx;
    logic                            chk_later;
    logic                            sid_ok;
    logic [psp_pkg::SRV_IDX_W-1:0]   sid_idx;
    logic                            take_found;
    psp_pkg::prio_t                  take_low;
    psp_pkg::cnt_vec_t               wc_dec;
    enq_t                            enq;

    assign action             = action_reg;
    assign server_sel         = sidx_reg;
    assign started_priority   = started_reg;
    assign preempted_priority = pre_reg;
    assign lost_priority      = lost_reg;
    assign last               = last_reg;
    assign sts.last           = last_next;

    // clamp the arriving priority into 1..PRIORITIES
    always_comb
    begin
        if (job_priority == '0)
        begin
            k_clamped = psp_pkg::PRIO_W'(1);
        end
        else if (job_priority > psp_pkg::PRIO_W'(psp_pkg::PRIORITIES))
        begin
            k_clamped = psp_pkg::PRIO_W'(psp_pkg::PRIORITIES);
        end
        else
        begin
            k_clamped = job_priority;
        end
    end

    // server searches
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        pre_found  = 1'b0;
        pre_idx    = '0;
        pre_low    = '0;
        chk_found  = 1'b0;
        chk_idx    = '0;
        chk_later  = 1'b0;
        for (int i = 0; i < psp_pkg::SERVERS; i++)
        begin
            if (!free_found && (srv_reg[i] == '0))
            begin
                free_found = 1'b1;
                free_idx   = psp_pkg::SRV_IDX_W'(i);
            end
        end
        for (int lo = psp_pkg::PRIORITIES; lo >= 1; lo--)
        begin
            for (int i = 0; i < psp_pkg::SERVERS; i++)
            begin
                if (!pre_found && (lo > int'(k_reg))
                    && (srv_reg[i] == psp_pkg::PRIO_W'(lo)))
                begin
                    pre_found = 1'b1;
                    pre_idx   = psp_pkg::SRV_IDX_W'(i);
                    pre_low   = psp_pkg::PRIO_W'(lo);
                end
            end
        end
        for (int i = 0; i < psp_pkg::SERVERS; i++)
        begin
            if (!chk_found && (i >= int'(cur_reg)) && (srv_reg[i] > psp_pkg::PRIO_W'(1)))
            begin
                chk_found = 1'b1;
                chk_idx   = psp_pkg::SRV_IDX_W'(i);
            end
        end
        for (int i = 0; i < psp_pkg::SERVERS; i++)
        begin
            if (chk_found && (i > int'(chk_idx)) && (srv_reg[i] > psp_pkg::PRIO_W'(1)))
            begin
                chk_later = 1'b1;
            end
        end
    end

    // completion: highest waiting priority
    always_comb
    begin
        sid_ok     = ({1'b0, sid_reg} < (psp_pkg::SID_W + 1)'(psp_pkg::SERVERS));
        sid_idx    = sid_reg[psp_pkg::SRV_IDX_W-1:0];
        take_found = 1'b0;
        take_low   = '0;
        for (int lo = 1; lo <= psp_pkg::PRIORITIES; lo++)
        begin
            if (!take_found && (wc_reg[lo-1] != '0))
            begin
                take_found = 1'b1;
                take_low   = psp_pkg::PRIO_W'(lo);
            end
        end
    end

    // one step of the current event
    always_comb
    begin
        srv_next     = srv_reg;
        wc_next      = wc_reg;
        cur_next     = cur_reg;
        nres_next    = nres_reg + 1'b1;
        action_next  = psp_pkg::ACT_NONE;
        sidx_next    = '0;
        started_next = '0;
        pre_next     = '0;
        lost_next    = '0;
        last_next    = 1'b1;
        wc_dec       = wc_reg;
        wc_dec[0]    = wc_reg[0] - 1'b1;
        enq          = enqueue(wc_reg, k_reg, qlim_reg);
        case (func_reg)
            psp_pkg::FN_ARRIVE:
            begin
                if (free_found)
                begin
                    srv_next[free_idx] = k_reg;
                    action_next        = psp_pkg::ACT_START;
                    sidx_next          = psp_pkg::SID_W'(free_idx);
                    started_next       = k_reg;
                end
                else if ((wc_reg[0] >= thr_reg) && pre_found)
                begin
                    enq               = enqueue(wc_reg, pre_low, qlim_reg);
                    srv_next[pre_idx] = k_reg;
                    wc_next           = enq.wc;
                    action_next       = psp_pkg::ACT_PREEMPT;
                    sidx_next         = psp_pkg::SID_W'(pre_idx);
                    started_next      = k_reg;
                    pre_next          = pre_low;
                    lost_next         = enq.lost;
                end
                else
                begin
                    wc_next      = enq.wc;
                    started_next = k_reg;
                    lost_next    = enq.lost;
                    action_next  = (enq.lost == k_reg) ? psp_pkg::ACT_REFUSED
                                                       : psp_pkg::ACT_QUEUED;
                end
            end
            psp_pkg::FN_COMPLETE:
            begin
                if (sid_ok && (srv_reg[sid_idx] != '0))
                begin
                    sidx_next = sid_reg;
                    if (take_found)
                    begin
                        wc_next[psp_pkg::PIDX_W'(take_low - 1'b1)] =
                            wc_reg[psp_pkg::PIDX_W'(take_low - 1'b1)] - 1'b1;
                        srv_next[sid_idx] = take_low;
                        action_next       = psp_pkg::ACT_START;
                        started_next      = take_low;
                    end
                    else
                    begin
                        srv_next[sid_idx] = '0;
                        action_next       = psp_pkg::ACT_IDLE;
                    end
                end
            end
            psp_pkg::FN_CHECK:
            begin
                if (en_reg && chk_found && (wc_reg[0] != '0)
                    && (nres_reg < psp_pkg::NRES_W'(psp_pkg::MAX_RESULTS)))
                begin
                    enq               = enqueue(wc_dec, srv_reg[chk_idx], qlim_reg);
                    srv_next[chk_idx] = psp_pkg::PRIO_W'(1);
                    wc_next           = enq.wc;
                    cur_next          = psp_pkg::CUR_W'(chk_idx) + 1'b1;
                    action_next       = psp_pkg::ACT_PREEMPT;
                    sidx_next         = psp_pkg::SID_W'(chk_idx);
                    started_next      = psp_pkg::PRIO_W'(1);
                    pre_next          = srv_reg[chk_idx];
                    lost_next         = enq.lost;
                    // more to come only if top-priority jobs remain and a later
                    // server still runs a lower priority
                    last_next = !((wc_dec[0] != '0) && chk_later
                                  && (nres_next < psp_pkg::NRES_W'(psp_pkg::MAX_RESULTS)));
                end
            end
            default:
            begin
                action_next = psp_pkg::ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psp_pkg::SERVERS; i++)
            begin
                srv_reg[i] <= '0;
            end
            wc_reg   <= '0;
            qlim_reg <= psp_pkg::QUEUE_LIMIT_RST;
            thr_reg  <= psp_pkg::THRESHOLD_RST;
            cur_reg  <= '0;
            nres_reg <= '0;
            en_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    psp_pkg::REG_QUEUE_LIMIT: qlim_reg <= cfg_data;
                    psp_pkg::REG_THRESHOLD:   thr_reg  <= cfg_data;
                    default:                  qlim_reg <= qlim_reg;
                endcase
            end
            if (cmd.load)
            begin
                cur_reg  <= '0;
                nres_reg <= '0;
                en_reg   <= (wc_reg[0] >= thr_reg);
            end
            else if (cmd.step)
            begin
                srv_reg  <= srv_next;
                wc_reg   <= wc_next;
                cur_reg  <= cur_next;
                nres_reg <= nres_next;
            end
        end
    end

    // event and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            k_reg    <= k_clamped;
            sid_reg  <= server_id;
        end
        if (cmd.step)
        begin
            action_reg  <= action_next;
            sidx_reg    <= sidx_next;
            started_reg <= started_next;
            pre_reg     <= pre_next;
            lost_reg    <= lost_next;
            last_reg    <= last_next;
        end
    end

endmodule

FILE: design/priority_server_preempt_scheduler.sv
// Preemptive priority scheduler for a fixed pool of servers.
// evt channel: one event per transfer. func selects arrival, completion or
//   preemption check; job_priority is used by arrivals (1 is highest, out of
//   range values are clamped), server_id by completions.
// res channel: one or more results per event, in order; last marks the final
//   result of an event. Arrivals, completions and unused codes give one result,
//   a check gives one result per preempted server (up to four) or a single
//   no-change result.
// cfg port: write queue_limit (index 0) or preempt_threshold (index 1) with
//   cfg_we; write only while no event is in flight.
// Timing: an event transfers when the block is idle, then the sequencer issues
//   one result per cycle into the output register while res.ready lets that
//   register drain. An arrival or completion is accepted and then takes one step;
//   a check takes one step per result. The single shared step unit sets the rate.
// Reset: all servers idle, all waiting counts zero, queue_limit 6 and
//   preempt_threshold 2; no result is pending.
// Stall: a result waits in the output register while res.ready is low and the
//   sequencer holds; the next event may still transfer once the last step is done.
module priority_server_preempt_scheduler
(
    input  logic                           clk,
    input  logic                           rst_n,
    psp_evt_if.sink                        evt,
    psp_res_if.source                      res,
    input  logic                           cfg_we,
    input  logic [psp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psp_pkg::CFG_W-1:0]      cfg_data
);

    psp_pkg::cmd_t cmd;
    psp_pkg::sts_t sts;

    // sequencer: accept, step, hand results to the output register
    psp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // server table, waiting counts, configuration and result payload
    psp_dp u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .func               (evt.func),
        .job_priority       (evt.job_priority),
        .server_id          (evt.server_id),
        .action             (res.action),
        .server_sel         (res.server_sel),
        .started_priority   (res.started_priority),
        .preempted_priority (res.preempted_priority),
        .lost_priority      (res.lost_priority),
        .last               (res.last)
    );

endmodule

FILE: sim/psp_sched_check.sv
`timescale 1ns / 1ps

module psp_sched_check
(
    input  logic                          clk,
    input  logic                          rst_n,
    psp_evt_if                            evt,
    psp_res_if                            res,
    input  logic                          cfg_we,
    input  logic [psp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [psp_pkg::CFG_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic [psp_pkg::ACT_W-1:0] action;
        logic [psp_pkg::SID_W-1:0] server_sel;
        psp_pkg::prio_t            started;
        psp_pkg::prio_t            preempted;
        psp_pkg::prio_t            lost;
        logic                      last;
    } sched_result_t;

    psp_pkg::prio_t srv_prio[psp_pkg::SERVERS];
    psp_pkg::cnt_t  wait_cnt[psp_pkg::PRIORITIES];
    psp_pkg::cnt_t  q_limit;
    psp_pkg::cnt_t  threshold;
    sched_result_t  expected_results[$];
    sched_result_t  seen;
    sched_result_t  want;
    int             errors_seen = 0;

    function automatic sched_result_t make_result(input logic [psp_pkg::ACT_W-1:0] act,
                                                  input int srv,
                                                  input psp_pkg::prio_t st,
                                                  input psp_pkg::prio_t pre,
                                                  input psp_pkg::prio_t lo);
        sched_result_t r;
        r.action     = act;
        r.server_sel = psp_pkg::SID_W'(srv);
        r.started    = st;
        r.preempted  = pre;
        r.lost       = lo;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic string describe(input sched_result_t r);
        return $sformatf("act=%0d srv=%0d start=%0d pre=%0d lost=%0d last=%0d",
                         r.action, r.server_sel, r.started, r.preempted, r.lost, r.last);
    endfunction

    // Queue a job; return the priority that got lost to a full queue, 0 if none.
    function automatic psp_pkg::prio_t queue_job(input psp_pkg::prio_t p);
        int total;
        int q;
        total = 0;
        for (q = 0; q < psp_pkg::PRIORITIES; q++)
            total += wait_cnt[q];
        if (total < q_limit) begin
            wait_cnt[p-1] = wait_cnt[p-1] + 1'b1;
            return '0;
        end
        for (q = psp_pkg::PRIORITIES; q > p; q--) begin
            if (wait_cnt[q-1] != 0) begin
                wait_cnt[q-1] = wait_cnt[q-1] - 1'b1;
                wait_cnt[p-1] = wait_cnt[p-1] + 1'b1;
                return psp_pkg::PRIO_W'(q);
            end
        end
        return p;
    endfunction

    task automatic predict_event(input logic [psp_pkg::FUNC_W-1:0] fn,
                                 input psp_pkg::prio_t jp,
                                 input logic [psp_pkg::SID_W-1:0] sid);
        sched_result_t  batch[$];
        psp_pkg::prio_t k;
        psp_pkg::prio_t lost;
        psp_pkg::prio_t cur;
        bit             placed;
        int             s;
        int             q;
        k = jp;
        if (k < 1)
            k = psp_pkg::PRIO_W'(1);
        if (k > psp_pkg::PRIORITIES)
            k = psp_pkg::PRIO_W'(psp_pkg::PRIORITIES);
        placed = 1'b0;
        if (fn == psp_pkg::FN_ARRIVE) begin
            for (s = 0; s < psp_pkg::SERVERS && !placed; s++) begin
                if (srv_prio[s] == 0) begin
                    srv_prio[s] = k;
                    batch = {batch, make_result(psp_pkg::ACT_START, s, k, '0, '0)};
                    placed = 1'b1;
                end
            end
            // absolute preemption: take the lowest-priority busy server below k
            if (!placed && wait_cnt[0] >= threshold) begin
                for (q = psp_pkg::PRIORITIES; q > k && !placed; q--) begin
                    for (s = 0; s < psp_pkg::SERVERS && !placed; s++) begin
                        if (srv_prio[s] == q) begin
                            srv_prio[s] = k;
                            lost = queue_job(psp_pkg::PRIO_W'(q));
                            batch = {batch, make_result(psp_pkg::ACT_PREEMPT, s, k,
                                                        psp_pkg::PRIO_W'(q), lost)};
                            placed = 1'b1;
                        end
                    end
                end
            end
            if (!placed) begin
                lost = queue_job(k);
                if (lost == k)
                    batch = {batch, make_result(psp_pkg::ACT_REFUSED, 0, k, '0, k)};
                else
                    batch = {batch, make_result(psp_pkg::ACT_QUEUED, 0, k, '0, lost)};
            end
        end else if (fn == psp_pkg::FN_COMPLETE) begin
            if (sid >= psp_pkg::SERVERS || srv_prio[sid] == 0) begin
                batch = {batch, make_result(psp_pkg::ACT_NONE, 0, '0, '0, '0)};
            end else begin
                srv_prio[sid] = '0;
                for (q = 1; q <= psp_pkg::PRIORITIES && !placed; q++) begin
                    if (wait_cnt[q-1] != 0) begin
                        wait_cnt[q-1] = wait_cnt[q-1] - 1'b1;
                        srv_prio[sid] = psp_pkg::PRIO_W'(q);
                        batch = {batch, make_result(psp_pkg::ACT_START, int'(sid),
                                                    psp_pkg::PRIO_W'(q), '0, '0)};
                        placed = 1'b1;
                    end
                end
                if (!placed)
                    batch = {batch, make_result(psp_pkg::ACT_IDLE, int'(sid), '0, '0, '0)};
            end
        end else if (fn == psp_pkg::FN_CHECK) begin
            if (wait_cnt[0] >= threshold) begin
                for (s = 0; s < psp_pkg::SERVERS && batch.size() < psp_pkg::MAX_RESULTS;
                     s++) begin
                    cur = srv_prio[s];
                    if (cur > 1 && wait_cnt[0] != 0) begin
                        wait_cnt[0] = wait_cnt[0] - 1'b1;
                        srv_prio[s] = psp_pkg::PRIO_W'(1);
                        lost = queue_job(cur);
                        batch = {batch, make_result(psp_pkg::ACT_PREEMPT, s,
                                                    psp_pkg::PRIO_W'(1), cur, lost)};
                    end
                end
            end
            if (batch.size() == 0)
                batch = {batch, make_result(psp_pkg::ACT_NONE, 0, '0, '0, '0)};
        end else begin
            batch = {batch, make_result(psp_pkg::ACT_NONE, 0, '0, '0, '0)};
        end
        batch[batch.size()-1].last = 1'b1;
        expected_results = {expected_results, batch};
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            foreach (srv_prio[s])
                srv_prio[s] = '0;
            foreach (wait_cnt[q])
                wait_cnt[q] = '0;
            q_limit     = psp_pkg::QUEUE_LIMIT_RST;
            threshold   = psp_pkg::THRESHOLD_RST;
            errors_seen = 0;
            expected_results.delete();
            pending    <= 0;
            fail_count <= 0;
        end else begin
            // results first: a result can never belong to an event taken at this edge
            if (res.valid && res.ready) begin
                seen = '{res.action, res.server_sel, res.started_priority,
                         res.preempted_priority, res.lost_priority, res.last};
                if (expected_results.size() == 0) begin
                    errors_seen++;
                    $display("%0t: unexpected result, expected none, got %s",
                             $time, describe(seen));
                end else begin
                    want = expected_results.pop_front();
                    if (seen.action !== want.action || seen.server_sel !== want.server_sel
                        || seen.started !== want.started || seen.preempted !== want.preempted
                        || seen.lost !== want.lost || seen.last !== want.last) begin
                        errors_seen++;
                        $display("%0t: result mismatch, expected %s, got %s",
                                 $time, describe(want), describe(seen));
                    end
                end
            end
            if (evt.valid && evt.ready)
                predict_event(evt.func, evt.job_priority, evt.server_id);
            if (cfg_we) begin
                case (cfg_index)
                    psp_pkg::REG_QUEUE_LIMIT: q_limit   = cfg_data;
                    psp_pkg::REG_THRESHOLD:   threshold = cfg_data;
                    default: ;
                endcase
            end
            pending    <= expected_results.size();
            fail_count <= errors_seen;
        end
    end

endmodule

FILE: sim/tb_priority_server_preempt_scheduler.sv
`timescale 1ns / 1ps

module tb_priority_server_preempt_scheduler;

    // func code that the block has no meaning for
    localparam logic [psp_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 43;

    logic                          clk   = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we;
    logic [psp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [psp_pkg::CFG_W-1:0]     cfg_data;
    int                            fail_count;
    int                            pending;
    bit                            calm = 1'b0;
    int                            res_hold;

    // queue_limit / preempt_threshold per random phase; phase 5 is drawn at run time.
    // Order matters: the deep queue built under limit 63 is left standing when the
    // limit drops to 1, so the queue sits above its limit for a while.
    int phase_limit[PHASES]  = '{63, 1, 0, 40, 63, 20, 6};
    int phase_thresh[PHASES] = '{63, 1, 0, 5, 0, 20, 2};

    psp_evt_if evt_bus();
    psp_res_if res_bus();

    priority_server_preempt_scheduler u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    psp_sched_check u_sched_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt_bus),
        .res        (res_bus),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure: drop ready for bursts of random length, none when calm.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_hold      <= 0;
            res_bus.ready <= 1'b0;
        end
        else if (res_hold != 0)
        begin
            res_hold      <= res_hold - 1;
            res_bus.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            res_hold      <= $urandom_range(0, 4);
            res_bus.ready <= 1'b0;
        end
        else
        begin
            res_bus.ready <= 1'b1;
        end
    end

    // Offer one event and hold it until the block takes the transfer. Valid stays
    // high on return so back-to-back events follow without a gap; the caller drops it.
    task automatic send_event(input logic [psp_pkg::FUNC_W-1:0] fn,
                              input psp_pkg::prio_t jp,
                              input logic [psp_pkg::SID_W-1:0] sid);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            evt_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        evt_bus.valid        <= 1'b1;
        evt_bus.func         <= fn;
        evt_bus.job_priority <= jp;
        evt_bus.server_id    <= sid;
        do
            @(posedge clk);
        while (!evt_bus.ready);
    endtask

    // Mostly legal priorities and live servers; now and then clamped priorities and
    // out-of-range server ids. Unused fields are random too so every bit toggles.
    task automatic send_random();
        int                           pick;
        logic [psp_pkg::FUNC_W-1:0]   fn;
        psp_pkg::prio_t               jp;
        logic [psp_pkg::SID_W-1:0]    sid;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            jp = psp_pkg::PRIO_W'($urandom_range(0, 7));
        else
            jp = psp_pkg::PRIO_W'($urandom_range(1, psp_pkg::PRIORITIES));
        if ($urandom_range(0, 9) == 0)
            sid = psp_pkg::SID_W'($urandom_range(0, 15));
        else
            sid = psp_pkg::SID_W'($urandom_range(0, psp_pkg::SERVERS - 1));
        if (pick < 45)
            fn = psp_pkg::FN_ARRIVE;
        else if (pick < 80)
            fn = psp_pkg::FN_COMPLETE;
        else if (pick < 95)
            fn = psp_pkg::FN_CHECK;
        else
            fn = FN_UNUSED;
        send_event(fn, jp, sid);
    endtask

    // Wait until every predicted result has been seen, then let the
    // sequencer go quiet.
    task automatic settle();
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_config(input logic [psp_pkg::CFG_W-1:0] limit,
                               input logic [psp_pkg::CFG_W-1:0] thresh);
        cfg_we    <= 1'b1;
        cfg_index <= psp_pkg::REG_QUEUE_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_index <= psp_pkg::REG_THRESHOLD;
        cfg_data  <= thresh;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        evt_bus.valid        <= 1'b0;
        evt_bus.func         <= psp_pkg::FN_ARRIVE;
        evt_bus.job_priority <= '0;
        evt_bus.server_id    <= '0;
        cfg_we               <= 1'b0;
        cfg_index            <= psp_pkg::REG_QUEUE_LIMIT;
        cfg_data             <= '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk under reset settings (queue limit 6, threshold 2).
        send_event(psp_pkg::FN_COMPLETE, 3'd1, 4'd2);   // completion of an idle server
        send_event(psp_pkg::FN_CHECK, 3'd1, 4'd0);      // check with nothing waiting
        send_event(psp_pkg::FN_ARRIVE, 3'd1, 4'd0);     // first free server
        send_event(psp_pkg::FN_COMPLETE, 3'd1, 4'd0);   // server goes idle, nothing waiting
        send_event(psp_pkg::FN_ARRIVE, 3'd0, 4'd0);     // priority 0 clamps to 1
        send_event(psp_pkg::FN_ARRIVE, 3'd7, 4'd0);     // priority 7 clamps to the lowest
        send_event(psp_pkg::FN_ARRIVE, 3'd2, 4'd0);
        send_event(psp_pkg::FN_ARRIVE, 3'd2, 4'd0);     // all servers busy now
        send_event(psp_pkg::FN_ARRIVE, 3'd2, 4'd0);     // queued
        send_event(psp_pkg::FN_ARRIVE, 3'd1, 4'd0);     // queued, below threshold
        send_event(psp_pkg::FN_ARRIVE, 3'd1, 4'd0);     // top-priority backlog at threshold
        send_event(psp_pkg::FN_ARRIVE, 3'd1, 4'd0);     // preempts a low-priority server
        send_event(psp_pkg::FN_CHECK, 3'd0, 4'd0);      // several servers preempted at once
        send_event(psp_pkg::FN_CHECK, 3'd0, 4'd0);      // backlog gone, no change
        send_event(psp_pkg::FN_ARRIVE, 3'd2, 4'd0);
        send_event(psp_pkg::FN_ARRIVE, 3'd2, 4'd0);     // fills the queue
        send_event(psp_pkg::FN_ARRIVE, 3'd2, 4'd0);     // nothing lower to displace: refused
        send_event(psp_pkg::FN_ARRIVE, 3'd1, 4'd0);     // displaces a waiting low job
        send_event(psp_pkg::FN_COMPLETE, 3'd0, 4'd15);  // server id far out of range
        send_event(psp_pkg::FN_COMPLETE, 3'd0, 4'd4);   // first server id past the pool
        send_event(FN_UNUSED, 3'd7, 4'd15);             // unused func code
        send_event(psp_pkg::FN_COMPLETE, 3'd0, 4'd0);   // pulls the highest waiting job
        send_event(psp_pkg::FN_COMPLETE, 3'd0, 4'd3);
        evt_bus.valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (p == 5)
                load_config(psp_pkg::CFG_W'($urandom_range(0, 63)),
                            psp_pkg::CFG_W'($urandom_range(0, 63)));
            else
                load_config(psp_pkg::CFG_W'(phase_limit[p]),
                            psp_pkg::CFG_W'(phase_thresh[p]));
            // one stretch with no idling mid-run, and none in the final phase
            calm <= (p == 3) || (p == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random();
            evt_bus.valid <= 1'b0;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/psp_pkg.sv
design/psp_evt_if.sv
design/psp_res_if.sv
design/psp_ctrl.sv
design/psp_dp.sv
design/priority_server_preempt_scheduler.sv
sim/psp_sched_check.sv
sim/tb_priority_server_preempt_scheduler.sv
